FILE: rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam int LENGTH_BITS = 16;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [15:0] HI_SURR_MIN = 16'hd800;
    localparam logic [15:0] HI_SURR_MAX = 16'hdbff;
    localparam logic [15:0] LO_SURR_MIN = 16'hdc00;
    localparam logic [15:0] LO_SURR_MAX = 16'hdfff;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_QUOTE   = 3'd1,
        ST_BAD_ESC    = 3'd2,
        ST_BAD_HEX    = 3'd3,
        ST_BAD_SURR   = 3'd4,
        ST_CTRL_CHAR  = 3'd5
    } status_t;

    typedef enum logic [5:0] {
        M_BODY = 6'b000001,
        M_ESC  = 6'b000010,
        M_HEX1 = 6'b000100,
        M_BSL2 = 6'b001000,
        M_U2   = 6'b010000,
        M_HEX2 = 6'b100000
    } mode_t;

    // Up to four UTF-8 bytes, element 0 leaves first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
    } utf8_t;

    // Results caused by one input beat.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            last;
        status_t         status;
        logic [15:0]     length;
    } group_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } esc_t;

    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r.value = b[3:0];
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r.value = 4'(b[2:0] + 3'd1) + 4'd8;
        else
            r.ok = 1'b0;
        return r;
    endfunction

    function automatic esc_t esc_char(input logic [7:0] b);
        esc_t r;
        r.ok = 1'b1;
        unique case (b)
            8'h22:   r.value = 8'h22;
            8'h5c:   r.value = 8'h5c;
            8'h2f:   r.value = 8'h2f;
            8'h62:   r.value = 8'h08;
            8'h66:   r.value = 8'h0c;
            8'h6e:   r.value = 8'h0a;
            8'h72:   r.value = 8'h0d;
            8'h74:   r.value = 8'h09;
            default:
            begin
                r.ok    = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic utf8_t utf8_encode(input logic [20:0] u);
        utf8_t r;
        r.bytes = '0;
        if (u <= 21'h7f)
        begin
            r.cnt      = 3'd1;
            r.bytes[0] = u[7:0];
        end
        else if (u <= 21'h7ff)
        begin
            r.cnt      = 3'd2;
            r.bytes[0] = {3'b110, u[10:6]};
            r.bytes[1] = {2'b10, u[5:0]};
        end
        else if (u <= 21'hffff)
        begin
            r.cnt      = 3'd3;
            r.bytes[0] = {4'b1110, u[15:12]};
            r.bytes[1] = {2'b10, u[11:6]};
            r.bytes[2] = {2'b10, u[5:0]};
        end
        else
        begin
            r.cnt      = 3'd4;
            r.bytes[0] = {5'b11110, u[20:18]};
            r.bytes[1] = {2'b10, u[17:12]};
            r.bytes[2] = {2'b10, u[11:6]};
            r.bytes[3] = {2'b10, u[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if
// Valid/ready channels for raw string bytes and decoded result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_dec_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [2:0]  status;
    logic [15:0] str_length;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output status, output str_length, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                    input status, input str_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape and surrogate state machine; forms the result group of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           take,
    input  wire logic [7:0]     in_byte,
    output jsu_pkg::group_t     grp
);

    localparam int LB = jsu_pkg::LENGTH_BITS;

    jsu_pkg::mode_t  mode_reg, mode_next;
    logic [1:0]      hex_cnt_reg, hex_cnt_next;
    logic [15:0]     code_high_reg, code_high_next;
    logic [15:0]     code_low_reg, code_low_next;
    logic [LB-1:0]   byte_count_reg, byte_count_next;

    jsu_pkg::hex_t   hx;
    jsu_pkg::esc_t   ec;
    jsu_pkg::utf8_t  enc;
    logic [15:0]     high_shift, low_shift;
    logic [20:0]     pair_code;
    logic [31:0]     count_ext;
    logic [LB:0]     count_sum;

    assign hx         = jsu_pkg::hex_value(in_byte);
    assign ec         = jsu_pkg::esc_char(in_byte);
    assign high_shift = {code_high_reg[11:0], hx.value};
    assign low_shift  = {code_low_reg[11:0], hx.value};
    assign pair_code  = {1'b0, code_high_reg[9:0], low_shift[9:0]} + 21'h10000;
    assign count_ext  = 32'(byte_count_reg);

    always_comb
    begin
        mode_next      = mode_reg;
        hex_cnt_next   = hex_cnt_reg;
        code_high_next = code_high_reg;
        code_low_next  = code_low_reg;
        grp            = '0;
        grp.length     = (count_ext > 32'hffff) ? 16'hffff : count_ext[15:0];
        enc            = '0;

        unique case (mode_reg)
            jsu_pkg::M_BODY:
            begin
                priority if (in_byte == jsu_pkg::CH_QUOTE)
                begin
                    grp.last   = 1'b1;
                    grp.status = jsu_pkg::ST_OK;
                end
                else if (in_byte == jsu_pkg::CH_BSLASH)
                    mode_next = jsu_pkg::M_ESC;
                else if (in_byte == 8'h00)
                begin
                    grp.last   = 1'b1;
                    grp.status = jsu_pkg::ST_NO_QUOTE;
                end
                else if (in_byte < jsu_pkg::CH_SPACE)
                begin
                    grp.last   = 1'b1;
                    grp.status = jsu_pkg::ST_CTRL_CHAR;
                end
                else
                begin
                    grp.cnt      = 3'd1;
                    grp.bytes[0] = in_byte;
                end
            end
            jsu_pkg::M_ESC:
            begin
                priority if (in_byte == jsu_pkg::CH_U)
                begin
                    mode_next      = jsu_pkg::M_HEX1;
                    hex_cnt_next   = 2'd0;
                    code_high_next = '0;
                end
                else if (ec.ok)
                begin
                    mode_next    = jsu_pkg::M_BODY;
                    grp.cnt      = 3'd1;
                    grp.bytes[0] = ec.value;
                end
                else
                begin
                    grp.last   = 1'b1;
                    grp.status = jsu_pkg::ST_BAD_ESC;
                end
            end
            jsu_pkg::M_HEX1:
            begin
                priority if (!hx.ok)
                begin
                    grp.last   = 1'b1;
                    grp.status = jsu_pkg::ST_BAD_HEX;
                end
                else if (hex_cnt_reg != 2'd3)
                begin
                    code_high_next = high_shift;
                    hex_cnt_next   = hex_cnt_reg + 2'd1;
                end
                else if (high_shift >= jsu_pkg::HI_SURR_MIN &&
                         high_shift <= jsu_pkg::HI_SURR_MAX)
                begin
                    code_high_next = high_shift;
                    mode_next      = jsu_pkg::M_BSL2;
                end
                else
                begin
                    code_high_next = high_shift;
                    mode_next      = jsu_pkg::M_BODY;
                    enc            = jsu_pkg::utf8_encode({5'd0, high_shift});
                    grp.cnt        = enc.cnt;
                    grp.bytes      = enc.bytes;
                end
            end
            jsu_pkg::M_BSL2:
            begin
                if (in_byte == jsu_pkg::CH_BSLASH)
                    mode_next = jsu_pkg::M_U2;
                else
                begin
                    grp.last   = 1'b1;
                    grp.status = jsu_pkg::ST_BAD_SURR;
                end
            end
            jsu_pkg::M_U2:
            begin
                if (in_byte == jsu_pkg::CH_U)
                begin
                    mode_next     = jsu_pkg::M_HEX2;
                    hex_cnt_next  = 2'd0;
                    code_low_next = '0;
                end
                else
                begin
                    grp.last   = 1'b1;
                    grp.status = jsu_pkg::ST_BAD_SURR;
                end
            end
            jsu_pkg::M_HEX2:
            begin
                priority if (!hx.ok)
                begin
                    grp.last   = 1'b1;
                    grp.status = jsu_pkg::ST_BAD_SURR;
                end
                else if (hex_cnt_reg != 2'd3)
                begin
                    code_low_next = low_shift;
                    hex_cnt_next  = hex_cnt_reg + 2'd1;
                end
                else if (low_shift < jsu_pkg::LO_SURR_MIN ||
                         low_shift > jsu_pkg::LO_SURR_MAX)
                begin
                    grp.last   = 1'b1;
                    grp.status = jsu_pkg::ST_BAD_SURR;
                end
                else
                begin
                    code_low_next = low_shift;
                    mode_next     = jsu_pkg::M_BODY;
                    enc           = jsu_pkg::utf8_encode(pair_code);
                    grp.cnt       = enc.cnt;
                    grp.bytes     = enc.bytes;
                end
            end
            default:
                mode_next = jsu_pkg::M_BODY;
        endcase

        if (grp.last)
            grp.cnt = 3'd1;
        else
            grp.length = '0;

        count_sum = {1'b0, byte_count_reg} + (LB+1)'(grp.cnt);

        if (grp.last)
            byte_count_next = '0;
        else if (count_sum[LB])
            byte_count_next = '1;
        else
            byte_count_next = count_sum[LB-1:0];

        if (grp.last)
        begin
            mode_next      = jsu_pkg::M_BODY;
            hex_cnt_next   = 2'd0;
            code_high_next = '0;
            code_low_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= jsu_pkg::M_BODY;
            hex_cnt_reg    <= 2'd0;
            code_high_reg  <= '0;
            code_low_reg   <= '0;
            byte_count_reg <= '0;
        end
        else if (take)
        begin
            mode_reg       <= mode_next;
            hex_cnt_reg    <= hex_cnt_next;
            code_high_reg  <= code_high_next;
            code_low_reg   <= code_low_next;
            byte_count_reg <= byte_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body decoder: unescapes and emits UTF-8, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle while raw.ready is high. Plain bytes and
// single-letter escapes give one result beat, registered in the result buffer.
// A \uXXXX escape gives 1 to 3 beats and a surrogate pair 4, all issued in
// order from a four-entry result buffer; raw.ready stays low until that buffer
// hands out its last beat. A closing quote or an error gives one beat with
// last set, status and the decoded length, after which the decoder is back in
// the string body state.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic  clk,
    input  wire logic  rst_n,
    jsu_raw_if.sink    raw,
    jsu_dec_if.source  dec
);

    jsu_pkg::group_t  grp;
    logic             take;
    logic             pop;
    logic             drained;

    logic [3:0][7:0]  buf_bytes_reg;
    logic [2:0]       buf_cnt_reg;
    logic             buf_last_reg;
    logic [2:0]       buf_status_reg;
    logic [15:0]      buf_len_reg;

    assign pop       = dec.valid && dec.ready;
    assign drained   = (buf_cnt_reg == 3'd0) || (pop && buf_cnt_reg == 3'd1);
    assign raw.ready = drained;
    assign take      = raw.valid && raw.ready;

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (raw.in_byte),
        .grp     (grp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buf_cnt_reg <= 3'd0;
        else if (take && grp.cnt != 3'd0)
            buf_cnt_reg <= grp.cnt;
        else if (pop)
            buf_cnt_reg <= buf_cnt_reg - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (take && grp.cnt != 3'd0)
        begin
            buf_bytes_reg  <= grp.bytes;
            buf_last_reg   <= grp.last;
            buf_status_reg <= grp.status;
            buf_len_reg    <= grp.length;
        end
        else if (pop)
            buf_bytes_reg <= {8'h00, buf_bytes_reg[3:1]};
    end

    assign dec.valid      = buf_cnt_reg != 3'd0;
    assign dec.out_byte   = buf_last_reg ? 8'h00 : buf_bytes_reg[0];
    assign dec.byte_valid = !buf_last_reg;
    assign dec.last       = buf_last_reg;
    assign dec.status     = buf_last_reg ? buf_status_reg : 3'd0;
    assign dec.str_length = buf_last_reg ? buf_len_reg : 16'd0;

endmodule

`default_nettype wire

FILE: rtl/core/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the JSON string decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        raw_valid,
    input wire logic        raw_ready,
    input wire logic        dec_valid,
    input wire logic        dec_ready,
    input wire logic [7:0]  out_byte,
    input wire logic        byte_valid,
    input wire logic        last,
    input wire logic [2:0]  status,
    input wire logic [15:0] str_length
);

    // Stalled result beat holds.
    a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |=> dec_valid && $stable(out_byte) && $stable(last))
        else $error("result beat changed while stalled");

    // Empty output never stalls input.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !dec_valid |-> raw_ready)
        else $error("input held off with empty output");

    a_last_form: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && last |-> !byte_valid && out_byte == 8'h00 &&
            status <= jsu_pkg::ST_CTRL_CHAR)
        else $error("malformed end beat");

    a_byte_form: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !last |-> byte_valid && status == 3'd0 && str_length == 16'd0)
        else $error("malformed byte beat");

    // A beat with a raw byte accepted and nothing pending leaves a result or idle.
    a_raw_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        raw_valid && raw_ready && !dec_valid |=> raw_ready || dec_valid)
        else $error("decoder stalled after accepting into empty buffer");

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .raw_valid  (raw.valid),
    .raw_ready  (raw.ready),
    .dec_valid  (dec.valid),
    .dec_ready  (dec.ready),
    .out_byte   (dec.out_byte),
    .byte_valid (dec.byte_valid),
    .last       (dec.last),
    .status     (dec.status),
    .str_length (dec.str_length)
);

`default_nettype wire

FILE: tb/json_string_unescape_utf8_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// Self-checking bench for the JSON string body decoder.
// ----------------------------------------------------------------------------
// Raw body bytes go in on a valid/ready channel. Decoded beats come back on a
// second channel and are matched in order against beats worked out by a
// behavioral decoder kept inside the bench. A short table of hand-picked bytes
// comes first, then random string bodies (mostly well formed, some broken).
// Both channels stall at random, and once the result side holds off long
// enough to back the decoder up.
// ----------------------------------------------------------------------------

module json_string_unescape_utf8_tb;

    localparam int          LIMIT_CYCLES    = 500_000;
    localparam int          RANDOM_ITEMS    = 360;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          DRAIN_CYCLES    = 16;

    localparam logic [7:0]  ESC_B = 8'h62;
    localparam logic [7:0]  ESC_F = 8'h66;
    localparam logic [7:0]  ESC_N = 8'h6e;
    localparam logic [7:0]  ESC_R = 8'h72;
    localparam logic [7:0]  ESC_T = 8'h74;

    typedef struct {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             last;
        jsu_pkg::status_t status;
        logic [15:0]      str_length;
    } dec_beat_t;

    typedef struct packed {
        logic [7:0]       in_byte;
        logic             typed;
        jsu_pkg::status_t status;
        logic [15:0]      str_length;
    } stim_row_t;

    // Rows marked typed carry the closing beat that the byte must give.
    localparam stim_row_t DIRECTED [26] = '{
        '{8'h22, 1'b1, jsu_pkg::ST_OK,        16'd0},
        '{8'h00, 1'b1, jsu_pkg::ST_NO_QUOTE,  16'd0},
        '{8'h1f, 1'b1, jsu_pkg::ST_CTRL_CHAR, 16'd0},
        '{8'hff, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h20, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h7f, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h5c, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h6e, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h5c, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h00, 1'b1, jsu_pkg::ST_BAD_ESC,   16'd4},
        '{8'h5c, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h75, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h44, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h38, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h30, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h30, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h5c, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h75, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h64, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h43, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h30, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h30, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h22, 1'b1, jsu_pkg::ST_OK,        16'd4},
        '{8'h5c, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h75, 1'b0, jsu_pkg::ST_OK,        16'd0},
        '{8'h47, 1'b1, jsu_pkg::ST_BAD_HEX,   16'd0}
    };

    logic clk;
    logic rst_n;

    jsu_raw_if raw_ch ();
    jsu_dec_if dec_ch ();

    json_string_unescape_utf8 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .dec   (dec_ch)
    );

    // Decoder state mirrored by the bench.
    jsu_pkg::mode_t                  dec_mode;
    logic [1:0]                      digit_idx;
    logic [15:0]                     unit_hi;
    logic [15:0]                     unit_lo;
    logic [jsu_pkg::LENGTH_BITS-1:0] decoded_count;

    dec_beat_t   expected_beats [$];
    dec_beat_t   fresh_beats [$];
    logic [7:0]  body_q [$];

    int          fail_count;
    int          cycle_count;
    bit          quiet_stretch;
    bit          hold_off_req;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------------
    function automatic void restart_body();
        dec_mode      = jsu_pkg::M_BODY;
        digit_idx     = 2'd0;
        unit_hi       = 16'd0;
        unit_lo       = 16'd0;
        decoded_count = '0;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        dec_beat_t beat;
        beat.out_byte   = b;
        beat.byte_valid = 1'b1;
        beat.last       = 1'b0;
        beat.status     = jsu_pkg::ST_OK;
        beat.str_length = 16'd0;
        fresh_beats.push_back(beat);
        if (decoded_count != '1)
            decoded_count++;
    endfunction

    function automatic void end_string(input jsu_pkg::status_t st);
        dec_beat_t beat;
        beat.out_byte   = 8'd0;
        beat.byte_valid = 1'b0;
        beat.last       = 1'b1;
        beat.status     = st;
        beat.str_length = (32'(decoded_count) > 32'hffff) ? 16'hffff : 16'(decoded_count);
        fresh_beats.push_back(beat);
        restart_body();
    endfunction

    function automatic void emit_code(input logic [20:0] u);
        if (u <= 21'h7f)
            emit_byte(u[7:0]);
        else if (u <= 21'h7ff)
        begin
            emit_byte(8'(u >> 6) | 8'hc0);
            emit_byte(8'(u & 21'h3f) | 8'h80);
        end
        else if (u <= 21'hffff)
        begin
            emit_byte(8'(u >> 12) | 8'he0);
            emit_byte(8'((u >> 6) & 21'h3f) | 8'h80);
            emit_byte(8'(u & 21'h3f) | 8'h80);
        end
        else
        begin
            emit_byte(8'((u >> 18) & 21'h07) | 8'hf0);
            emit_byte(8'((u >> 12) & 21'h3f) | 8'h80);
            emit_byte(8'((u >> 6) & 21'h3f) | 8'h80);
            emit_byte(8'(u & 21'h3f) | 8'h80);
        end
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return int'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66)
            return int'(b - 8'h61) + 10;
        if (b >= 8'h41 && b <= 8'h46)
            return int'(b - 8'h41) + 10;
        return -1;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int nib;
        fresh_beats.delete();
        case (dec_mode)
            jsu_pkg::M_BODY:
            begin
                if (b == jsu_pkg::CH_QUOTE)
                    end_string(jsu_pkg::ST_OK);
                else if (b == jsu_pkg::CH_BSLASH)
                    dec_mode = jsu_pkg::M_ESC;
                else if (b == 8'h00)
                    end_string(jsu_pkg::ST_NO_QUOTE);
                else if (b < jsu_pkg::CH_SPACE)
                    end_string(jsu_pkg::ST_CTRL_CHAR);
                else
                    emit_byte(b);
            end
            jsu_pkg::M_ESC:
            begin
                dec_mode = jsu_pkg::M_BODY;
                case (b)
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                        emit_byte(b);
                    ESC_B: emit_byte(8'h08);
                    ESC_F: emit_byte(8'h0c);
                    ESC_N: emit_byte(8'h0a);
                    ESC_R: emit_byte(8'h0d);
                    ESC_T: emit_byte(8'h09);
                    jsu_pkg::CH_U:
                    begin
                        dec_mode  = jsu_pkg::M_HEX1;
                        digit_idx = 2'd0;
                        unit_hi   = 16'd0;
                    end
                    default: end_string(jsu_pkg::ST_BAD_ESC);
                endcase
            end
            jsu_pkg::M_HEX1:
            begin
                nib = hex_nibble(b);
                if (nib < 0)
                    end_string(jsu_pkg::ST_BAD_HEX);
                else
                begin
                    unit_hi = {unit_hi[11:0], 4'(nib)};
                    if (digit_idx != 2'd3)
                        digit_idx++;
                    else if (unit_hi >= jsu_pkg::HI_SURR_MIN && unit_hi <= jsu_pkg::HI_SURR_MAX)
                        dec_mode = jsu_pkg::M_BSL2;
                    else
                    begin
                        dec_mode = jsu_pkg::M_BODY;
                        emit_code(21'(unit_hi));
                    end
                end
            end
            jsu_pkg::M_BSL2:
            begin
                if (b != jsu_pkg::CH_BSLASH)
                    end_string(jsu_pkg::ST_BAD_SURR);
                else
                    dec_mode = jsu_pkg::M_U2;
            end
            jsu_pkg::M_U2:
            begin
                if (b != jsu_pkg::CH_U)
                    end_string(jsu_pkg::ST_BAD_SURR);
                else
                begin
                    dec_mode  = jsu_pkg::M_HEX2;
                    digit_idx = 2'd0;
                    unit_lo   = 16'd0;
                end
            end
            jsu_pkg::M_HEX2:
            begin
                nib = hex_nibble(b);
                if (nib < 0)
                    end_string(jsu_pkg::ST_BAD_SURR);
                else
                begin
                    unit_lo = {unit_lo[11:0], 4'(nib)};
                    if (digit_idx != 2'd3)
                        digit_idx++;
                    else if (unit_lo < jsu_pkg::LO_SURR_MIN || unit_lo > jsu_pkg::LO_SURR_MAX)
                        end_string(jsu_pkg::ST_BAD_SURR);
                    else
                    begin
                        dec_mode = jsu_pkg::M_BODY;
                        emit_code(21'({unit_hi[9:0], unit_lo[9:0]}) + 21'h10000);
                    end
                end
            end
            default: dec_mode = jsu_pkg::M_BODY;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Raw byte source
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (!quiet_stretch && $urandom_range(0, 99) < 18)
        begin
            raw_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        raw_ch.valid   <= 1'b1;
        raw_ch.in_byte <= b;
        @(posedge clk);
        while (!raw_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_predicted(input logic [7:0] b);
        send_byte(b);
        decode_byte(b);
        foreach (fresh_beats[i])
            expected_beats.push_back(fresh_beats[i]);
    endtask

    // ------------------------------------------------------------------------
    // Random body builder
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void push_hex_digits(input logic [15:0] code, input int count);
        for (int i = 3; i > 3 - count; i--)
            body_q.push_back(hex_char(code[i*4 +: 4]));
    endfunction

    function automatic void push_u_escape(input logic [15:0] code);
        body_q.push_back(jsu_pkg::CH_BSLASH);
        body_q.push_back(jsu_pkg::CH_U);
        push_hex_digits(code, 4);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(8'h20, 8'hff));
        while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (hex_nibble(b) >= 0);
        return b;
    endfunction

    function automatic logic [7:0] bad_escape_letter();
        logic [7:0] b;
        do
            b = $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255));
        while (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                         ESC_B, ESC_F, ESC_N, ESC_R, ESC_T, jsu_pkg::CH_U});
        return b;
    endfunction

    function automatic logic [15:0] random_high_surr();
        return 16'($urandom_range(jsu_pkg::HI_SURR_MIN, jsu_pkg::HI_SURR_MAX));
    endfunction

    function automatic void push_good_token();
        logic [7:0]  letters [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                                     ESC_B, ESC_F, ESC_N, ESC_R, ESC_T};
        logic [15:0] code;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            body_q.push_back(plain_byte());
        else if (pick < 62)
        begin
            body_q.push_back(jsu_pkg::CH_BSLASH);
            body_q.push_back(letters[$urandom_range(0, 7)]);
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 4))
                0: code = 16'($urandom_range(0, 16'h7f));
                1: code = 16'($urandom_range(16'h80, 16'h7ff));
                2: code = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                3: code = 16'($urandom_range(jsu_pkg::LO_SURR_MIN, jsu_pkg::LO_SURR_MAX));
                default:
                begin
                    do
                        code = 16'($urandom_range(16'h800, 16'hffff));
                    while (code >= jsu_pkg::HI_SURR_MIN && code <= jsu_pkg::HI_SURR_MAX);
                end
            endcase
            push_u_escape(code);
        end
        else
        begin
            push_u_escape(random_high_surr());
            push_u_escape(16'($urandom_range(jsu_pkg::LO_SURR_MIN, jsu_pkg::LO_SURR_MAX)));
        end
    endfunction

    function automatic void push_broken_tail();
        logic [7:0]  b;
        logic [15:0] code;
        case ($urandom_range(0, 7))
            0: body_q.push_back(8'h00);
            1: body_q.push_back(8'($urandom_range(1, 31)));
            2:
            begin
                body_q.push_back(jsu_pkg::CH_BSLASH);
                body_q.push_back(bad_escape_letter());
            end
            3:
            begin
                body_q.push_back(jsu_pkg::CH_BSLASH);
                body_q.push_back(jsu_pkg::CH_U);
                push_hex_digits(16'($urandom_range(0, 16'hffff)), $urandom_range(0, 3));
                body_q.push_back(non_hex_byte());
            end
            4:
            begin
                push_u_escape(random_high_surr());
                do
                    b = 8'($urandom_range(0, 255));
                while (b == jsu_pkg::CH_BSLASH);
                body_q.push_back(b);
            end
            5:
            begin
                push_u_escape(random_high_surr());
                body_q.push_back(jsu_pkg::CH_BSLASH);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == jsu_pkg::CH_U);
                body_q.push_back(b);
            end
            6:
            begin
                push_u_escape(random_high_surr());
                body_q.push_back(jsu_pkg::CH_BSLASH);
                body_q.push_back(jsu_pkg::CH_U);
                push_hex_digits(16'($urandom_range(0, 16'hffff)), $urandom_range(0, 3));
                body_q.push_back(non_hex_byte());
            end
            default:
            begin
                push_u_escape(random_high_surr());
                do
                    code = 16'($urandom_range(0, 16'hffff));
                while (code >= jsu_pkg::LO_SURR_MIN && code <= jsu_pkg::LO_SURR_MAX);
                push_u_escape(code);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------------
    function automatic void field_mismatch(input string name, input int unsigned want,
                                           input int unsigned got);
        fail_count++;
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    endfunction

    function automatic void check_beat();
        dec_beat_t want;
        if (expected_beats.size() == 0)
        begin
            fail_count++;
            $error("beat with nothing expected: out_byte %0h last %0b status %0d",
                   dec_ch.out_byte, dec_ch.last, dec_ch.status);
            return;
        end
        want = expected_beats.pop_front();
        if (dec_ch.out_byte !== want.out_byte)
            field_mismatch("out_byte", want.out_byte, dec_ch.out_byte);
        if (dec_ch.byte_valid !== want.byte_valid)
            field_mismatch("byte_valid", want.byte_valid, dec_ch.byte_valid);
        if (dec_ch.last !== want.last)
            field_mismatch("last", want.last, dec_ch.last);
        if (dec_ch.status !== want.status)
            field_mismatch("status", want.status, dec_ch.status);
        if (dec_ch.str_length !== want.str_length)
            field_mismatch("str_length", want.str_length, dec_ch.str_length);
    endfunction

    initial
    begin
        int hold_left;
        hold_left    = 0;
        dec_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (dec_ch.valid && dec_ch.ready)
                check_beat();
            if (hold_left > 0)
            begin
                hold_left--;
                dec_ch.ready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
                dec_ch.ready <= 1'b0;
            end
            else
                dec_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= 22);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        dec_beat_t closing;
        int        random_sent;
        int        ntok;

        rst_n          = 1'b0;
        raw_ch.valid   = 1'b0;
        raw_ch.in_byte = 8'h00;
        fail_count     = 0;
        quiet_stretch  = 1'b0;
        hold_off_req   = 1'b0;
        random_sent    = 0;
        restart_body();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i].in_byte);
            decode_byte(DIRECTED[i].in_byte);
            if (DIRECTED[i].typed)
            begin
                closing.out_byte   = 8'd0;
                closing.byte_valid = 1'b0;
                closing.last       = 1'b1;
                closing.status     = DIRECTED[i].status;
                closing.str_length = DIRECTED[i].str_length;
                expected_beats.push_back(closing);
            end
            else
                foreach (fresh_beats[j])
                    expected_beats.push_back(fresh_beats[j]);
        end

        hold_off_req = 1'b1;
        while (random_sent < RANDOM_ITEMS)
        begin
            body_q.delete();
            ntok = $urandom_range(0, 10);
            repeat (ntok) push_good_token();
            if ($urandom_range(0, 99) < 20)
                push_broken_tail();
            else
                body_q.push_back(jsu_pkg::CH_QUOTE);
            quiet_stretch = (random_sent >= 140 && random_sent < 220);
            foreach (body_q[i])
                send_predicted(body_q[i]);
            random_sent += body_q.size();
        end
        quiet_stretch = 1'b0;

        raw_ch.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_beats.size() != 0)
        begin
            fail_count++;
            $error("%0d expected beats never arrived", expected_beats.size());
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_if.sv
rtl/core/jsu_decode.sv
rtl/core/json_string_unescape_utf8.sv
rtl/core/jsu_checker.sv
tb/json_string_unescape_utf8_tb.sv
